// File: sv/grid_bfs_shortest_path_macros.svh
// assertion macros shared by the checker
`ifndef GRID_BFS_SHORTEST_PATH_MACROS_SVH
`define GRID_BFS_SHORTEST_PATH_MACROS_SVH

// clocked assertion, off while reset is high
`define GBFS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define GBFS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/gbfs_pkg.sv
// shared types and constants for the grid shortest path block
package gbfs_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_GRID_ROWS = 3'd0;
   localparam logic [2:0] REG_GRID_COLS = 3'd1;
   localparam logic [2:0] REG_START_ROW = 3'd2;
   localparam logic [2:0] REG_START_COL = 3'd3;
   localparam logic [2:0] REG_DEST_ROW  = 3'd4;
   localparam logic [2:0] REG_DEST_COL  = 3'd5;

   // map entry codes: bit 0 blocked, bit 1 visited
   localparam logic [1:0] MAP_FREE    = 2'b00;
   localparam logic [1:0] MAP_BLOCKED = 2'b01;
   localparam logic [1:0] MAP_VISITED = 2'b10;

   // neighbor offsets, right, left, down, up
   localparam logic signed [1:0] ROW_STEP [4] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1};
   localparam logic signed [1:0] COL_STEP [4] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0};

   typedef struct packed {
      logic clr_write;
      logic load_mine;
      logic init;
      logic pop;
      logic take_cell;
      logic nb_check;
      logic next_k;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic start_ok;
      logic start_hit;
      logic q_empty;
      logic nb_valid;
      logic nb_free;
      logic nb_dest;
      logic k_last;
   } dp_status_type;

endpackage

// File: sv/gbfs_ram.sv
// generic single write, single read ram with registered read
module gbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/gbfs_dp.sv
// datapath: map and queue memories, search counters, result register
module gbfs_dp #(
   parameter int MAX_DIM = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gbfs_pkg::dp_cmd_type    cmd,
   output gbfs_pkg::dp_status_type status,
   input  logic [7:0]             mine_row,
   input  logic [7:0]             mine_col,
   input  logic [8:0]             grid_rows,
   input  logic [8:0]             grid_cols,
   input  logic [7:0]             start_row,
   input  logic [7:0]             start_col,
   input  logic [7:0]             dest_row,
   input  logic [7:0]             dest_col,
   output logic [15:0]            rsp_distance,
   output logic                   rsp_reached
);
   import gbfs_pkg::*;

   localparam int RW    = $clog2(MAX_DIM);
   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(CELLS);
   localparam int QW    = 2 * RW;
   localparam int LW    = AW + 1;
   localparam int XW    = ((RW > 9) ? RW : 9) + 2;
   localparam logic [XW-1:0] MAXD_X    = XW'(MAX_DIM);
   localparam logic [AW-1:0] MAXD_A    = AW'(MAX_DIM);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

   logic [LW-1:0] head_ff, tail_ff, lvl_end_ff, level_ff;
   logic [RW-1:0] cell_row_ff, cell_col_ff;
   logic [1:0]    k_ff;
   logic [AW-1:0] clr_ff;
   logic          hit_ff;
   logic [15:0]   dist_ff;
   logic [15:0]   rsp_distance_ff;
   logic          rsp_reached_ff;

   logic [XW-1:0] rows_eff, cols_eff;
   logic signed [XW-1:0] nr, nc;
   logic [RW-1:0] nb_row, nb_col, st_row, st_col;
   logic [AW-1:0] nb_addr, st_addr, mine_addr;
   logic          mine_ok;
   logic [LW:0]   lvl_next;
   logic [15:0]   dist_sat;

   logic          map_we;
   logic [AW-1:0] map_waddr;
   logic [1:0]    map_wdata, map_rdata;
   logic          q_we;
   logic [AW-1:0] q_waddr;
   logic [QW-1:0] q_wdata, q_rdata;

   assign rows_eff = (XW'(grid_rows) > MAXD_X) ? MAXD_X : XW'(grid_rows);
   assign cols_eff = (XW'(grid_cols) > MAXD_X) ? MAXD_X : XW'(grid_cols);

   assign nr = $signed(XW'({1'b0, cell_row_ff})) + $signed(XW'(ROW_STEP[k_ff]));
   assign nc = $signed(XW'({1'b0, cell_col_ff})) + $signed(XW'(COL_STEP[k_ff]));
   assign nb_row  = nr[RW-1:0];
   assign nb_col  = nc[RW-1:0];
   assign nb_addr = AW'(nb_row) * MAXD_A + AW'(nb_col);

   assign st_row  = RW'(start_row);
   assign st_col  = RW'(start_col);
   assign st_addr = AW'(st_row) * MAXD_A + AW'(st_col);

   assign mine_ok   = (XW'(mine_row) < MAXD_X) && (XW'(mine_col) < MAXD_X);
   assign mine_addr = AW'(RW'(mine_row)) * MAXD_A + AW'(RW'(mine_col));

   assign lvl_next = {1'b0, level_ff} + (LW+1)'(1);
   assign dist_sat = (32'(lvl_next) > 32'hFFFF) ? 16'hFFFF : 16'(lvl_next);

   assign status.clr_done  = (clr_ff == LAST_CELL);
   assign status.start_ok  = (XW'(start_row) < rows_eff) && (XW'(start_col) < cols_eff);
   assign status.start_hit = (start_row == dest_row) && (start_col == dest_col);
   assign status.q_empty   = (head_ff == tail_ff);
   assign status.nb_valid  = !nr[XW-1] && !nc[XW-1] &&
                             ($unsigned(nr) < rows_eff) && ($unsigned(nc) < cols_eff);
   assign status.nb_free   = (map_rdata == MAP_FREE);
   assign status.nb_dest   = ($unsigned(nr) == XW'(dest_row)) &&
                             ($unsigned(nc) == XW'(dest_col));
   assign status.k_last    = (k_ff == 2'd3);

   // map port select
   always_comb begin
      map_we    = 1'b0;
      map_waddr = nb_addr;
      map_wdata = MAP_VISITED;
      priority if (cmd.clr_write) begin
         map_we    = 1'b1;
         map_waddr = clr_ff;
         map_wdata = MAP_FREE;
      end else if (cmd.load_mine) begin
         map_we    = mine_ok;
         map_waddr = mine_addr;
         map_wdata = MAP_BLOCKED;
      end else if (cmd.init) begin
         map_we    = status.start_ok;
         map_waddr = st_addr;
      end else if (cmd.nb_check) begin
         map_we    = status.nb_free;
      end else begin
         map_we    = 1'b0;
      end
   end

   always_comb begin
      q_we    = 1'b0;
      q_waddr = tail_ff[AW-1:0];
      q_wdata = {nb_row, nb_col};
      priority if (cmd.init) begin
         q_we    = status.start_ok;
         q_waddr = '0;
         q_wdata = {st_row, st_col};
      end else if (cmd.nb_check) begin
         q_we    = status.nb_free;
      end else begin
         q_we    = 1'b0;
      end
   end

   gbfs_ram #(.WIDTH(2), .DEPTH(CELLS)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (nb_addr),
      .rd_data (map_rdata)
   );

   gbfs_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (head_ff[AW-1:0]),
      .rd_data (q_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         hit_ff  <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         if (cmd.clr_write) begin
            clr_ff <= status.clr_done ? '0 : clr_ff + AW'(1);
         end
         if (cmd.init) begin
            hit_ff     <= status.start_ok && status.start_hit;
            dist_ff    <= '0;
            head_ff    <= '0;
            tail_ff    <= status.start_ok ? LW'(1) : '0;
            level_ff   <= '0;
            lvl_end_ff <= LW'(1);
         end
         if (cmd.pop) begin
            head_ff <= head_ff + LW'(1);
            k_ff    <= '0;
            // first pop of a new level
            if (head_ff == lvl_end_ff) begin
               level_ff   <= level_ff + LW'(1);
               lvl_end_ff <= tail_ff;
            end
         end
         if (cmd.take_cell) begin
            {cell_row_ff, cell_col_ff} <= q_rdata;
         end
         if (cmd.next_k) begin
            k_ff <= k_ff + 2'd1;
         end
         if (cmd.nb_check && status.nb_free) begin
            tail_ff <= tail_ff + LW'(1);
            if (status.nb_dest) begin
               hit_ff  <= 1'b1;
               dist_ff <= dist_sat;
            end
         end
      end
      if (cmd.load_rsp) begin
         rsp_distance_ff <= hit_ff ? dist_ff : 16'd0;
         rsp_reached_ff  <= hit_ff;
      end
   end

   assign rsp_distance = rsp_distance_ff;
   assign rsp_reached  = rsp_reached_ff;
endmodule

// File: sv/gbfs_ctrl.sv
// controller: handshakes and search sequencing
module gbfs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_has_mine,
   input  logic                    req_last,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output gbfs_pkg::dp_cmd_type    cmd,
   input  gbfs_pkg::dp_status_type status
);
   import gbfs_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_INIT, S_POP, S_CELL, S_NB, S_CHK, S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept = req_valid && req_ready_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.load_mine = accept && req_has_mine;
            if (accept && req_last) state_in = S_INIT;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = (!status.start_ok || status.start_hit) ? S_RESULT : S_POP;
         end
         S_POP: begin
            if (status.q_empty) begin
               state_in = S_RESULT;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_CELL;
            end
         end
         S_CELL: begin
            cmd.take_cell = 1'b1;
            state_in      = S_NB;
         end
         S_NB: begin
            if (status.nb_valid) begin
               state_in = S_CHK;
            end else if (status.k_last) begin
               state_in = S_POP;
            end else begin
               cmd.next_k = 1'b1;
            end
         end
         S_CHK: begin
            cmd.nb_check = 1'b1;
            if (status.nb_free && status.nb_dest) begin
               state_in = S_RESULT;
            end else if (status.k_last) begin
               state_in = S_POP;
            end else begin
               cmd.next_k = 1'b1;
               state_in   = S_NB;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_CLEAR;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
endmodule

// File: sv/grid_bfs_shortest_path.sv
// Grid shortest path by breadth-first search, 4-neighbor.
// req channel: one word per cycle while idle; a word with has_mine marks
//   a blocked cell, a word with last starts a search from start_row/col.
// rsp channel: one word per search, distance and reached flag, held in an
//   output register until taken; loading continues while it waits.
// A search walks the queue: each popped cell is read from the queue, then its
//   neighbors are checked in turn; map and queue memories each give one
//   registered read.
// After a search the map is swept clean, one cell a cycle over all its
//   MAX_DIM*MAX_DIM cells, and no word is accepted meanwhile; the same
//   sweep runs after reset. A search whose result finds the output register
//   full waits there until rsp_ready frees it.
// Reset is synchronous: clears control and start/dest, grid dims to 256.
// csr: grid_rows, grid_cols, start_row, start_col, dest_row, dest_col at
//   byte addresses 0, 4, 8, 12, 16, 20.
module grid_bfs_shortest_path #(
   parameter int MAX_DIM = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_mine_row,
   input  logic [7:0]  req_mine_col,
   input  logic        req_has_mine,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_distance,
   output logic        rsp_reached,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import gbfs_pkg::*;

   logic [8:0] grid_rows_ff, grid_cols_ff;
   logic [7:0] start_row_ff, start_col_ff, dest_row_ff, dest_col_ff;
   logic [2:0] reg_idx;
   logic       wr_en;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign reg_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= 9'd256;
         grid_cols_ff <= 9'd256;
         start_row_ff <= '0;
         start_col_ff <= '0;
         dest_row_ff  <= '0;
         dest_col_ff  <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_GRID_ROWS: grid_rows_ff <= csr_pwdata[8:0];
            REG_GRID_COLS: grid_cols_ff <= csr_pwdata[8:0];
            REG_START_ROW: start_row_ff <= csr_pwdata[7:0];
            REG_START_COL: start_col_ff <= csr_pwdata[7:0];
            REG_DEST_ROW:  dest_row_ff  <= csr_pwdata[7:0];
            REG_DEST_COL:  dest_col_ff  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GRID_ROWS: csr_prdata = 32'(grid_rows_ff);
         REG_GRID_COLS: csr_prdata = 32'(grid_cols_ff);
         REG_START_ROW: csr_prdata = 32'(start_row_ff);
         REG_START_COL: csr_prdata = 32'(start_col_ff);
         REG_DEST_ROW:  csr_prdata = 32'(dest_row_ff);
         REG_DEST_COL:  csr_prdata = 32'(dest_col_ff);
         default:       csr_prdata = '0;
      endcase
   end

   gbfs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_has_mine (req_has_mine),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .status       (status)
   );

   gbfs_dp #(.MAX_DIM(MAX_DIM)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .mine_row     (req_mine_row),
      .mine_col     (req_mine_col),
      .grid_rows    (grid_rows_ff),
      .grid_cols    (grid_cols_ff),
      .start_row    (start_row_ff),
      .start_col    (start_col_ff),
      .dest_row     (dest_row_ff),
      .dest_col     (dest_col_ff),
      .rsp_distance (rsp_distance),
      .rsp_reached  (rsp_reached)
   );
endmodule

// File: sv/gbfs_chk.sv
// port checker for the grid shortest path block, with its bind
`include "grid_bfs_shortest_path_macros.svh"

module gbfs_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_distance,
   input logic        rsp_reached,
   input logic        csr_pready
);
   `GBFS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance) && $stable(rsp_reached), "rsp word changed while stalled")
   `GBFS_ASSERT(a_miss_zero, clock, reset, rsp_valid && !rsp_reached |-> rsp_distance == 16'd0, "unreached result with nonzero distance")
   `GBFS_ASSERT(a_no_early_rsp, clock, reset, req_valid && req_ready && !req_last && !rsp_valid |=> !rsp_valid, "result without a last word")
   `GBFS_ASSERT_ALWAYS(a_sweep_after_reset, clock, reset |=> !req_ready, "ready during clearing sweep")
   `GBFS_ASSERT_ALWAYS(a_pready, clock, csr_pready, "csr port stalled")
endmodule

bind grid_bfs_shortest_path gbfs_chk u_gbfs_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_last     (req_last),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_distance (rsp_distance),
   .rsp_reached  (rsp_reached),
   .csr_pready   (csr_pready)
);
